### src/lat_pkg.sv
// types, codes and helper functions shared by the local address table
`default_nettype none

package lat_pkg;

  // operation codes carried by each word
  typedef enum logic [2:0] {
    OP_SET_PRIMARY   = 3'd0,
    OP_ADD_SECONDARY = 3'd1,
    OP_DELETE        = 3'd2,
    OP_LOOKUP        = 3'd3,
    OP_BEST_MATCH    = 3'd4,
    OP_CLEAR         = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_INVALID   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  localparam int unsigned AddrW = 32;
  localparam int unsigned PlenW = 6;
  localparam logic [PlenW-1:0] PlenMax = 6'd32;

  // one stored entry
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [PlenW-1:0] plen;
  } entry_t;

  // per-cell update controls
  typedef struct packed {
    logic load;   // take the new entry
    logic shift;  // take the neighbour's entry
  } cell_ctrl_t;

  // saturate a prefix length at 32
  function automatic logic [PlenW-1:0] clamp_len(input logic [PlenW-1:0] len);
    return (len > PlenMax) ? PlenMax : len;
  endfunction

  // netmask for a prefix length of 0 to 32
  function automatic logic [AddrW-1:0] len_to_mask(input logic [PlenW-1:0] len);
    return ~({AddrW{1'b1}} >> len);
  endfunction

  // zero net, multicast or global broadcast
  function automatic logic addr_bad(input logic [AddrW-1:0] a);
    return (a[31:24] == 8'h00) || (a[31:28] == 4'hE) || (a == {AddrW{1'b1}});
  endfunction

  // class default prefix length
  function automatic logic [PlenW-1:0] default_len(input logic [AddrW-1:0] a);
    logic [PlenW-1:0] len;
    priority casez (a[31:29])
      3'b0??:  len = 6'd8;
      3'b10?:  len = 6'd16;
      3'b110:  len = 6'd24;
      default: len = 6'd32;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### src/lat_cell.sv
// one table cell: an entry register with its own exact and prefix comparators
`default_nettype none

module lat_cell (
  input  wire logic               clk_i,
  input  wire lat_pkg::cell_ctrl_t ctrl_i,
  input  wire lat_pkg::entry_t    new_i,
  input  wire lat_pkg::entry_t    next_i,
  input  wire logic [31:0]        key_addr_i,
  input  wire logic [5:0]         key_plen_i,
  input  wire logic [31:0]        key_mask_i,
  output lat_pkg::entry_t         entry_o,
  output logic                    hit_o,
  output logic                    best_o
);
  import lat_pkg::*;

  entry_t entry_q, entry_d;

  // load a new entry or take the neighbour's when the table closes a gap
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = new_i;
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // exact address compare
  assign hit_o = (entry_q.addr == key_addr_i);

  // nonzero entry, same prefix length, equal bits under the mask
  assign best_o = (entry_q.addr != '0) && (entry_q.plen == key_plen_i) &&
                  (((entry_q.addr ^ key_addr_i) & key_mask_i) == '0);

  assign entry_o = entry_q;

endmodule

`default_nettype wire

### src/ipv4_local_address_table.sv
// top level of the per-interface ipv4 local address table
//
//  channel   direction  handshake            payload
//  command   in         start_i / busy_o     operation_i, addr_i, prefix_len_i
//  result    out        done_o strobe        status_o, match_addr_o, match_index_o,
//                                            primary_addr_o, entry_count_o
//
// one word per clock: a command taken at an edge has its result on the ports
// for the following cycle with done_o high, and the table already updated.
// the cost of a word is one pass through the cells' comparators and the
// lowest-index priority pick; busy_o stays low, the table never stalls.
// reset clears the entry count and the result strobe; entry contents are
// not cleared and only entries below the count are ever read.
`default_nettype none

module ipv4_local_address_table #(
  parameter int unsigned MAX_ENTRIES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [31:0] addr_i,
  input  wire logic [5:0]  prefix_len_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [31:0]      match_addr_o,
  output logic [2:0]       match_index_o,
  output logic [31:0]      primary_addr_o,
  output logic [3:0]       entry_count_o
);
  import lat_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic                   accept;
  logic [CntW-1:0]        count_q, count_d;
  logic                   done_q;
  status_e                status_q, status_d;
  logic [31:0]            match_addr_q, match_addr_d;
  logic [2:0]             match_index_q, match_index_d;

  logic [5:0]             plen;
  logic [31:0]            mask;
  entry_t                 new_entry;
  entry_t                 entries [MAX_ENTRIES];
  entry_t                 nexts   [MAX_ENTRIES];
  cell_ctrl_t             ctrl    [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hit, best, live, hit_v, best_v;
  logic [IdxW-1:0]        hit_idx, best_idx;
  logic                   exists, any_best, full, bad;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // key preparation
  assign plen      = clamp_len(prefix_len_i);
  assign mask      = len_to_mask(plen);
  assign bad       = addr_bad(addr_i);
  assign new_entry = '{addr: addr_i, plen: (plen != '0) ? plen : default_len(addr_i)};
  assign full      = (count_q >= CntW'(MAX_ENTRIES));

  // row of cells, each handing its entry down to the one below
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign nexts[g] = entries[g];
    end else begin : g_mid
      assign nexts[g] = entries[g+1];
    end

    lat_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[g]),
      .new_i      (new_entry),
      .next_i     (nexts[g]),
      .key_addr_i (addr_i),
      .key_plen_i (plen),
      .key_mask_i (mask),
      .entry_o    (entries[g]),
      .hit_o      (hit[g]),
      .best_o     (best[g])
    );

    assign live[g]   = (CntW'(g) < count_q);
    assign hit_v[g]  = hit[g] && live[g];
    assign best_v[g] = best[g] && live[g];
  end

  // lowest-index pick over the cell flags
  always_comb begin
    hit_idx  = '0;
    best_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_v[i]) begin
        hit_idx = IdxW'(i);
      end
      if (best_v[i]) begin
        best_idx = IdxW'(i);
      end
    end
  end

  assign exists   = |hit_v;
  assign any_best = |best_v;

  // operation decode, cell controls and next result
  always_comb begin
    count_d       = count_q;
    status_d      = ST_OK;
    match_addr_d  = '0;
    match_index_d = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctrl[i] = '0;
    end
    if (accept) begin
      unique case (operation_i)
        OP_SET_PRIMARY: begin
          if (exists) begin
            status_d = ST_EXISTS;
          end else if (bad) begin
            status_d = ST_INVALID;
          end else begin
            ctrl[0].load = 1'b1;
            if (count_q == '0) begin
              count_d = CntW'(1);
            end
          end
        end
        OP_ADD_SECONDARY: begin
          if (full) begin
            status_d = ST_FULL;
          end else if (bad) begin
            status_d = ST_INVALID;
          end else if (exists) begin
            status_d = ST_EXISTS;
          end else begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              ctrl[i].load = (CntW'(i) == count_q);
            end
            count_d = count_q + CntW'(1);
          end
        end
        OP_DELETE: begin
          if (!exists) begin
            status_d = ST_NOT_FOUND;
          end else begin
            match_index_d = 3'(hit_idx);
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              ctrl[i].shift = (IdxW'(i) >= hit_idx) && (CntW'(i + 1) < count_q);
            end
            count_d = count_q - CntW'(1);
          end
        end
        OP_LOOKUP: begin
          if (!exists) begin
            status_d = ST_NOT_FOUND;
          end else begin
            match_index_d = 3'(hit_idx);
            match_addr_d  = addr_i;
          end
        end
        OP_BEST_MATCH: begin
          if (!any_best) begin
            status_d = ST_NOT_FOUND;
          end else begin
            match_index_d = 3'(best_idx);
            match_addr_d  = entries[best_idx].addr;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          // unused operation codes leave the table as it is
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      match_addr_q  <= match_addr_d;
      match_index_q <= match_index_d;
    end
  end

  // result ports
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign match_addr_o   = match_addr_q;
  assign match_index_o  = match_index_q;
  assign primary_addr_o = (count_q != '0) ? entries[0].addr : '0;
  assign entry_count_o  = 4'(count_q);

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted word gave no result");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (entry_count_o == 4'(MAX_ENTRIES)))
    else $error("table full reported below depth");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_NOT_FOUND) |-> (match_addr_o == '0))
    else $error("miss with nonzero match address");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_CLEAR) |=> (entry_count_o == '0))
    else $error("clear left entries");

endmodule

`default_nettype wire
